FILE: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Store depth, field widths, command codes and the structs passed along the
// cell row.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int DEPTH   = 16;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int OCC_W   = $clog2(DEPTH + 1);
	localparam int CAP_W   = 5;
	localparam int KEY_W   = 32;
	localparam int VAL_W   = 32;
	localparam int STAMP_W = 32;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_ACCESS = 1'b1
	} cmd_t;

	// search token walking the cell row
	typedef struct packed {
		logic               valid;
		cmd_t               cmd;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
		logic               found;
		logic [IDX_W-1:0]   found_idx;
		logic [VAL_W-1:0]   found_value;
		logic               have_min;
		logic [STAMP_W-1:0] min_stamp;
		logic [IDX_W-1:0]   min_idx;
	} tok_t;

	// write-back broadcast to every cell
	typedef struct packed {
		logic               en;
		logic               load;
		logic [IDX_W-1:0]   idx;
		logic [KEY_W-1:0]   key;
		logic [VAL_W-1:0]   value;
		logic [STAMP_W-1:0] stamp;
	} wr_t;

endpackage

FILE: rtl/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one slot of the LRU key-value cache
// Holds one key, value and use stamp; folds its entry into the passing
// search token and registers the token for the next cell.
// ----------------------------------------------------------------------------
module lkv_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lkv_pkg::IDX_W-1:0]   idx,
	input  logic [lkv_pkg::OCC_W-1:0]   occ,
	input  logic                        advance,
	input  lkv_pkg::tok_t               tok_in,
	output lkv_pkg::tok_t               tok_out,
	input  lkv_pkg::wr_t                wr
);

	logic [lkv_pkg::KEY_W-1:0]   key_q;
	logic [lkv_pkg::VAL_W-1:0]   value_q;
	logic [lkv_pkg::STAMP_W-1:0] stamp_q;
	lkv_pkg::tok_t               tok_q;
	lkv_pkg::tok_t               tok_nxt;
	logic                        active;

	assign active = lkv_pkg::OCC_W'(idx) < occ;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && active) begin
			// first match wins
			if (!tok_in.found && key_q == tok_in.key) begin
				tok_nxt.found       = 1'b1;
				tok_nxt.found_idx   = idx;
				tok_nxt.found_value = value_q;
			end
			// strict less keeps the lowest slot on equal stamps
			if (!tok_in.have_min || stamp_q < tok_in.min_stamp) begin
				tok_nxt.have_min  = 1'b1;
				tok_nxt.min_stamp = stamp_q;
				tok_nxt.min_idx   = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else if (advance) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.idx == idx) begin
			stamp_q <= wr.stamp;
			if (wr.load) begin
				key_q   <= wr.key;
				value_q <= wr.value;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// A row of DEPTH cells, each holding one entry. A search token walks the
// row one cell per cycle unless a stalled result holds the row, collecting
// the matching slot and the oldest stamp; a write-back then updates the chosen slot.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  in       | in_valid / in_stall  | command, key, value
//  out      | out_valid / out_stall| hit, data (access requests only)
//  cfg      | cfg_wen              | cfg_wdata -> capacity
//
//  Each request passes the launch register and then the DEPTH cells of the
//  row; its write-back also launches the next request.
//  One request is in flight at a time; the next is accepted in the
//  write-back cycle of the previous one.
//  Reset clears occupancy, the use counter and capacity (to 16); entries
//  are undefined until written and never read before that.
//  A stalled result holds the token at the end of the row, so an access
//  cannot finish until the output register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wen,
	input  logic [lkv_pkg::CAP_W-1:0]     cfg_wdata,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          command,
	input  logic [lkv_pkg::KEY_W-1:0]     key,
	input  logic signed [lkv_pkg::VAL_W-1:0] value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          hit,
	output logic signed [lkv_pkg::VAL_W-1:0] data
);

	localparam int DEPTH = lkv_pkg::DEPTH;

	logic [lkv_pkg::CAP_W-1:0]   cap_q;
	logic [lkv_pkg::OCC_W-1:0]   occ_q;
	logic [lkv_pkg::OCC_W-1:0]   cap_eff;
	logic [lkv_pkg::STAMP_W-1:0] use_q;
	logic [lkv_pkg::STAMP_W-1:0] use_nxt;
	logic                        busy_q;
	logic                        out_valid_q;
	logic                        hit_q;
	logic [lkv_pkg::VAL_W-1:0]   data_q;
	lkv_pkg::tok_t               tok_q;
	lkv_pkg::tok_t               chain [DEPTH+1];
	lkv_pkg::tok_t               last;
	lkv_pkg::wr_t                wr;
	logic                        accept;
	logic                        finish;
	logic                        advance;
	logic                        full;
	logic                        is_add;
	logic [DEPTH:0]              tok_valids;

	// capacity of zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lkv_pkg::OCC_W'(1);
		end else if (int'(cap_q) > DEPTH) begin
			cap_eff = lkv_pkg::OCC_W'(DEPTH);
		end else begin
			cap_eff = lkv_pkg::OCC_W'(cap_q);
		end
	end

	// counter saturates at all ones
	assign use_nxt = (use_q == '1) ? use_q : use_q + 1'b1;

	assign last    = chain[DEPTH];
	assign is_add  = last.cmd == lkv_pkg::CMD_ADD;
	// an access may finish only when the result register can take it
	assign finish  = last.valid && (is_add || !out_valid_q || !out_stall);
	// hold the whole row while the token waits at its end
	assign advance = !(last.valid && !finish);
	assign in_stall = busy_q && !finish;
	assign accept  = in_valid && !in_stall;
	assign full    = occ_q >= cap_eff;

	// launch register feeding the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q.valid <= 1'b0;
		end else if (accept) begin
			tok_q.valid       <= 1'b1;
			tok_q.cmd         <= lkv_pkg::cmd_t'(command);
			tok_q.key         <= key;
			tok_q.value       <= value;
			tok_q.stamp       <= use_nxt;
			tok_q.found       <= 1'b0;
			tok_q.found_idx   <= '0;
			tok_q.found_value <= '0;
			tok_q.have_min    <= 1'b0;
			tok_q.min_stamp   <= '0;
			tok_q.min_idx     <= '0;
		end else if (advance) begin
			tok_q.valid <= 1'b0;
		end
	end

	assign chain[0] = tok_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		lkv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (lkv_pkg::IDX_W'(i)),
			.occ     (occ_q),
			.advance (advance),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1]),
			.wr      (wr)
		);
	end

	// write-back: update a matching slot, else on an add insert or evict the oldest
	always_comb begin
		wr.en    = finish && (is_add || last.found);
		wr.load  = is_add;
		wr.key   = last.key;
		wr.value = last.value;
		wr.stamp = last.stamp;
		if (last.found) begin
			wr.idx = last.found_idx;
		end else if (full) begin
			wr.idx = last.min_idx;
		end else begin
			wr.idx = occ_q[lkv_pkg::IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= lkv_pkg::CAP_W'(16);
			occ_q  <= '0;
			use_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				use_q <= use_nxt;
			end
			// grow occupancy only on a fresh insert below capacity
			if (finish && is_add && !last.found && !full) begin
				occ_q <= occ_q + 1'b1;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && !is_add) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && !is_add) begin
			hit_q  <= last.found;
			data_q <= last.found ? last.found_value : '1;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign data      = data_q;

	for (genvar j = 0; j <= DEPTH; j++) begin : g_vld
		assign tok_valids[j] = chain[j].valid;
	end

	// at most one request travels the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valids))
		else $error("more than one token in the cell row");

	// no token without a request in flight
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> tok_valids == '0)
		else $error("token present while idle");

	// occupancy stays within the store
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= DEPTH)
		else $error("occupancy beyond depth");

	// use counter never goes backwards
	a_use_mono: assert property (@(posedge clk) disable iff (!arst_n)
		use_q >= $past(use_q))
		else $error("use counter decreased");

endmodule

FILE: tb/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Walks a directed table of add, access and capacity rows, then random
// phases over a small key pool at several capacities. A shadow copy of the
// store predicts every read result; results are compared in order of arrival.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

	localparam int HALF_PERIOD    = 10;
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
	localparam int SETTLE_CYCLES  = lkv_pkg::DEPTH + 4;
	localparam int PHASE_ITEMS    = 110;
	localparam int NUM_PHASES     = 10;
	localparam int QUIET_PHASE    = 8;     // no idling on either side
	localparam int HOLD_PHASE     = 9;     // receiver holds off for a while
	localparam int POOL_SIZE      = 20;
	localparam int NUM_ROWS       = 27;

	typedef enum logic { ROW_REQ, ROW_CAP } row_kind_t;

	typedef struct packed {
		logic                      hit;
		logic [lkv_pkg::VAL_W-1:0] data;
	} read_result_t;

	// one row of the directed plan; a capacity row carries the setting in value
	typedef struct packed {
		row_kind_t                 kind;
		lkv_pkg::cmd_t             cmd;
		logic [lkv_pkg::KEY_W-1:0] key;
		logic [lkv_pkg::VAL_W-1:0] value;
		logic                      typed;
		logic                      exp_hit;
		logic [lkv_pkg::VAL_W-1:0] exp_data;
	} plan_row_t;

	localparam plan_row_t DIRECTED [NUM_ROWS] = '{
		// empty store after reset: miss
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
		// update in place; a hit holding all ones differs from a miss only by hit
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
		// capacity below occupancy: entries stay, inserts replace the oldest
		'{ROW_CAP, lkv_pkg::CMD_ADD,    32'h0,         32'd2,         1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0001, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0001, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0002, 32'h0000_0002, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		// zero capacity behaves as one
		'{ROW_CAP, lkv_pkg::CMD_ADD,    32'h0,         32'd0,         1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0003, 32'h0000_0003, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0003, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		// capacity above the depth behaves as the depth
		'{ROW_CAP, lkv_pkg::CMD_ADD,    32'h0,         32'd31,        1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0004, 32'h0000_0004, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h0000_0005, 32'h0000_0005, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h0000_0005, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
		'{ROW_CAP, lkv_pkg::CMD_ADD,    32'h0,         32'd17,        1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ADD,    32'h1234_5678, 32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0},
		'{ROW_REQ, lkv_pkg::CMD_ACCESS, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
	};

	localparam int PHASE_CAP [NUM_PHASES] = '{16, 1, 0, 3, 31, 17, 8, 2, 16, 5};

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wen;
	logic [lkv_pkg::CAP_W-1:0]        cfg_wdata;
	logic                             in_valid;
	logic                             in_stall;
	logic                             command;
	logic [lkv_pkg::KEY_W-1:0]        key;
	logic signed [lkv_pkg::VAL_W-1:0] value;
	logic                             out_valid;
	logic                             out_stall;
	logic                             hit;
	logic signed [lkv_pkg::VAL_W-1:0] data;

	// shadow copy of the store
	logic [lkv_pkg::KEY_W-1:0]   shadow_key   [lkv_pkg::DEPTH];
	logic [lkv_pkg::VAL_W-1:0]   shadow_val   [lkv_pkg::DEPTH];
	logic [lkv_pkg::STAMP_W-1:0] shadow_stamp [lkv_pkg::DEPTH];
	int                          shadow_occ;
	logic [lkv_pkg::STAMP_W-1:0] shadow_clock;
	logic [lkv_pkg::CAP_W-1:0]   shadow_cap;

	read_result_t                pending_reads [$];
	logic [lkv_pkg::KEY_W-1:0]   key_pool [POOL_SIZE];
	int                          mismatches;
	int                          quiet_count;
	bit                          jitter_on;
	bit                          hold_req;

	lru_key_value_cache i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.key       (key),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.data      (data)
	);

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Apply one request to the shadow store. Returns 1 when it yields a read
	// result, which is then placed in res.
	function automatic bit touch_entry(input lkv_pkg::cmd_t op,
			input logic [lkv_pkg::KEY_W-1:0] k,
			input logic [lkv_pkg::VAL_W-1:0] v, output read_result_t res);
		int slot;
		int oldest;
		int limit;
		slot = -1;
		res.hit = 1'b0;
		res.data = '1;
		// the use counter sticks at its top value
		if (shadow_clock != '1)
			shadow_clock++;
		for (int i = 0; i < shadow_occ; i++) begin
			if (slot < 0 && shadow_key[i] == k)
				slot = i;
		end
		if (op == lkv_pkg::CMD_ACCESS) begin
			if (slot >= 0) begin
				shadow_stamp[slot] = shadow_clock;
				res.hit = 1'b1;
				res.data = shadow_val[slot];
			end
			return 1'b1;
		end
		if (slot < 0) begin
			limit = (shadow_cap == 0) ? 1 :
				(shadow_cap > lkv_pkg::DEPTH) ? lkv_pkg::DEPTH : int'(shadow_cap);
			if (shadow_occ >= limit) begin
				// oldest stamp goes; a tie keeps the lowest slot
				oldest = 0;
				for (int i = 1; i < shadow_occ; i++) begin
					if (shadow_stamp[i] < shadow_stamp[oldest])
						oldest = i;
				end
				slot = oldest;
			end else begin
				slot = shadow_occ;
				shadow_occ++;
			end
			shadow_key[slot] = k;
		end
		shadow_val[slot] = v;
		shadow_stamp[slot] = shadow_clock;
		return 1'b0;
	endfunction

	// Offer one request, hold it until accepted, then predict its outcome.
	// A typed expectation, where given, replaces the predicted read result.
	task automatic send_request(input lkv_pkg::cmd_t op, input logic [lkv_pkg::KEY_W-1:0] k,
			input logic [lkv_pkg::VAL_W-1:0] v, input bit typed, input read_result_t want);
		read_result_t got;
		int gap;
		gap = (jitter_on && $urandom_range(99) < 29) ? $urandom_range(20, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= op;
		key      <= k;
		value    <= v;
		do
			@(posedge clk);
		while (in_stall);
		if (touch_entry(op, k, v, got))
			pending_reads.push_back(typed ? want : got);
	endtask

	// Let the block go idle, then write the capacity register.
	task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
		in_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		// an add in flight gives no result: allow it to finish
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_wen    <= 1'b0;
		shadow_cap  = cap;
	endtask

	// Receiver: random stalls, or a long hold-off on request.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				out_stall <= jitter_on && ($urandom_range(99) < 29);
			end
		end
	end

	// Compare each accepted read result with the oldest one predicted.
	always @(posedge clk) begin
		read_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reads.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected read result: hit=%0b data=%h", hit, data);
				mismatches++;
			end else begin
				want = pending_reads.pop_front();
				if (hit !== want.hit || data !== want.data) begin
					if (mismatches < 10)
						$display("read result: expected hit=%0b data=%h, got hit=%0b data=%h",
							want.hit, want.data, hit, data);
					mismatches++;
				end
			end
		end
	end

	// Drop the run when neither channel has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_count <= 0;
		end else if (quiet_count >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	initial begin
		plan_row_t                 row;
		read_result_t              want;
		lkv_pkg::cmd_t             op;
		logic [lkv_pkg::KEY_W-1:0] k;
		arst_n       = 1'b0;
		cfg_wen      = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		command      = lkv_pkg::CMD_ADD;
		key          = '0;
		value        = '0;
		mismatches   = 0;
		quiet_count  = 0;
		jitter_on    = 1'b1;
		hold_req     = 1'b0;
		shadow_occ   = 0;
		shadow_clock = '0;
		shadow_cap   = lkv_pkg::CAP_W'(16);
		for (int i = 0; i < lkv_pkg::DEPTH; i++) begin
			shadow_key[i]   = '0;
			shadow_val[i]   = '0;
			shadow_stamp[i] = '0;
		end
		// pool a little larger than the store, so hits and evictions both occur
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_ROWS; r++) begin
			row = DIRECTED[r];
			if (row.kind == ROW_CAP) begin
				write_capacity(row.value[lkv_pkg::CAP_W-1:0]);
			end else begin
				want.hit  = row.exp_hit;
				want.data = row.exp_data;
				send_request(row.cmd, row.key, row.value, row.typed, want);
			end
		end

		want = '0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(lkv_pkg::CAP_W'(PHASE_CAP[p]));
			jitter_on = (p != QUIET_PHASE);
			// keep offering while the receiver holds off, so the block backs up
			if (p == HOLD_PHASE)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = $urandom_range(1) ? lkv_pkg::CMD_ACCESS : lkv_pkg::CMD_ADD;
				k  = ($urandom_range(99) < 10) ? $urandom() : key_pool[$urandom_range(POOL_SIZE - 1)];
				send_request(op, k, $urandom(), 1'b0, want);
			end
		end
		jitter_on = 1'b1;

		in_valid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_reads.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
